>>> rtl/core/pfe_pkg.sv
// Shared constants for the postfix expression evaluator.
package pfe_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int DIV_STEP_W  = $clog2(DATA_W);

  // Character codes.
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_MUL     = 8'h2A;
  localparam logic [7:0] CH_DIV     = 8'h2F;
  localparam logic [7:0] CH_ADD     = 8'h2B;
  localparam logic [7:0] CH_SUB     = 8'h2D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Operator codes.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Error codes, equal to the reported status.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_MALFORMED = 2'd1;
  localparam logic [1:0] ERR_DIVZERO   = 2'd2;

  localparam logic [DATA_W-1:0] VALUE_MALFORMED = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] VALUE_DIVZERO   = 32'hFFFF_FC18;  // -1000

endpackage

>>> rtl/core/postfix_expression_evaluator_unit.sv
// Postfix expression evaluator: operand stack in a synchronous RAM, iterative divider.
//
// Usage: characters of a postfix expression come in on the in_ channel, one word
// each, with in_action low. Digits and other bytes push (byte - '0'); '+', '-', '*'
// and '/' pop two entries and push the result; space and newline are skipped.
// A word with in_action high finishes the expression: one result word goes out
// on the out_ channel (value, status), and stack and error are cleared.
// Status 0 is ok, 1 malformed (underflow, overflow, leftover entries) with value
// -1, 2 division by zero with value -1000. The first error sticks until finish.
// '+', '-', '*' do one RAM read of the second operand, then writeback; '/' runs
// the 32-step restoring divider between read and writeback. No new word is taken
// until an operator is done; push, skip and finish need no extra state.
// Latency: a finish word shows on out_valid the cycle after it is accepted.
// The result sits in an output register; symbol words keep flowing while it
// waits. A finish word is held off only while that register is full and
// out_ready is low. Reset (rst_n low, synchronous) empties the stack, clears the
// error and out_valid; RAM contents stay undefined, never read unwritten.
module postfix_expression_evaluator_unit
  import pfe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  logic [7:0]        in_symbol,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_value,
  output logic [1:0]        out_status
);

  localparam logic [1:0] S_IDLE = 2'd0;  // take a word
  localparam logic [1:0] S_OPRD = 2'd1;  // second operand arrives from RAM
  localparam logic [1:0] S_DIV  = 2'd2;  // divider iterating
  localparam logic [1:0] S_DWB  = 2'd3;  // sign fix and writeback of quotient

  // Operand stack. top_r mirrors the entry at cnt_r-1, so an operator needs
  // only one RAM read, at cnt_r-2, issued every cycle and used only in S_OPRD.
  // No write is made in the cycle the used read is issued, so no bypass is needed.
  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              we;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]        err_r, err_nxt;
  logic [DATA_W-1:0] top_r, top_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [ADDR_W-1:0] wb_addr_r, wb_addr_nxt;

  // Divider datapath
  logic [DATA_W-1:0]     rem_r, rem_nxt;
  logic [DATA_W-1:0]     quo_r, quo_nxt;
  logic [DATA_W-1:0]     dvs_r, dvs_nxt;
  logic                  neg_r, neg_nxt;
  logic [DIV_STEP_W-1:0] step_r, step_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic [1:0]        out_status_r, out_status_nxt;

  logic              in_fire;
  logic              is_skip;
  logic              is_op;
  logic [1:0]        sym_op;
  logic [CNT_W-1:0]  cnt_m2;
  logic [DATA_W-1:0] opn_n, opn_t;
  logic [DATA_W-1:0] mag_n, mag_t;
  logic [DATA_W-1:0] mul_res;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   rem_diff;
  logic [DATA_W-1:0] quo_fix;

  assign in_ready   = (state_r == S_IDLE) && (!in_action || !out_valid_r || out_ready);
  assign in_fire    = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  // Symbol decode
  always_comb begin
    is_skip = (in_symbol == CH_SPACE) || (in_symbol == CH_NEWLINE);
    is_op   = 1'b1;
    sym_op  = OP_ADD;
    unique case (in_symbol)
      CH_ADD:  sym_op = OP_ADD;
      CH_SUB:  sym_op = OP_SUB;
      CH_MUL:  sym_op = OP_MUL;
      CH_DIV:  sym_op = OP_DIV;
      default: is_op  = 1'b0;
    endcase
  end

  assign cnt_m2  = cnt_r - CNT_W'(2);
  assign opn_n   = rd_data_r;   // next entry
  assign opn_t   = top_r;       // top entry
  assign mag_n   = opn_n[DATA_W-1] ? (DATA_W'(0) - opn_n) : opn_n;
  assign mag_t   = opn_t[DATA_W-1] ? (DATA_W'(0) - opn_t) : opn_t;
  assign mul_res = opn_n * opn_t;

  // One restoring division step
  assign rem_sh   = {rem_r, quo_r[DATA_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};
  assign quo_fix  = neg_r ? (DATA_W'(0) - quo_r) : quo_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    err_nxt        = err_r;
    top_nxt        = top_r;
    op_nxt         = op_r;
    wb_addr_nxt    = wb_addr_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    dvs_nxt        = dvs_r;
    neg_nxt        = neg_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    we             = 1'b0;
    wr_addr        = cnt_r[ADDR_W-1:0];
    wr_data        = DATA_W'(in_symbol) - DATA_W'(CH_ZERO);
    rd_addr        = cnt_m2[ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_action) begin
            out_valid_nxt = 1'b1;
            priority if (err_r == ERR_DIVZERO) begin
              out_value_nxt  = VALUE_DIVZERO;
              out_status_nxt = ERR_DIVZERO;
            end else if (err_r != ERR_NONE || cnt_r != CNT_W'(1)) begin
              out_value_nxt  = VALUE_MALFORMED;
              out_status_nxt = ERR_MALFORMED;
            end else begin
              out_value_nxt  = top_r;
              out_status_nxt = ERR_NONE;
            end
            cnt_nxt = '0;
            err_nxt = ERR_NONE;
          end else if (err_r == ERR_NONE && !is_skip) begin
            if (is_op) begin
              if (cnt_r < CNT_W'(2)) begin
                err_nxt = ERR_MALFORMED;
              end else begin
                op_nxt      = sym_op;
                wb_addr_nxt = cnt_m2[ADDR_W-1:0];
                state_nxt   = S_OPRD;
              end
            end else if (cnt_r >= CNT_W'(STACK_DEPTH)) begin
              err_nxt = ERR_MALFORMED;
            end else begin
              we      = 1'b1;
              top_nxt = wr_data;
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end
        end
      end
      S_OPRD: begin
        wr_addr   = wb_addr_r;
        state_nxt = S_IDLE;
        unique case (op_r)
          OP_ADD: wr_data = opn_n + opn_t;
          OP_SUB: wr_data = opn_n - opn_t;
          OP_MUL: wr_data = mul_res;
          OP_DIV: wr_data = opn_t;
        endcase
        if (op_r == OP_DIV) begin
          if (opn_t == '0) begin
            err_nxt = ERR_DIVZERO;
            cnt_nxt = cnt_m2;
          end else begin
            rem_nxt   = '0;
            quo_nxt   = mag_n;
            dvs_nxt   = mag_t;
            neg_nxt   = opn_n[DATA_W-1] ^ opn_t[DATA_W-1];
            step_nxt  = DIV_STEP_W'(DATA_W - 1);
            state_nxt = S_DIV;
          end
        end else begin
          we      = 1'b1;
          top_nxt = wr_data;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_DIV: begin
        if (!rem_diff[DATA_W]) begin
          rem_nxt = rem_diff[DATA_W-1:0];
        end else begin
          rem_nxt = rem_sh[DATA_W-1:0];
        end
        quo_nxt = {quo_r[DATA_W-2:0], !rem_diff[DATA_W]};
        if (step_r == '0) begin
          state_nxt = S_DWB;
        end else begin
          step_nxt = step_r - DIV_STEP_W'(1);
        end
      end
      S_DWB: begin
        we        = 1'b1;
        wr_addr   = wb_addr_r;
        wr_data   = quo_fix;
        top_nxt   = quo_fix;
        cnt_nxt   = cnt_r - CNT_W'(1);
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Stack RAM, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      stack_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= stack_mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    top_r        <= top_nxt;
    op_r         <= op_nxt;
    wb_addr_r    <= wb_addr_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    dvs_r        <= dvs_nxt;
    neg_r        <= neg_nxt;
    step_r       <= step_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule
